### sv/tdlt_pkg.sv
// Package with the constants, payload types and offset helpers of the link transpose block.
package tdlt_pkg;

    localparam int LINKS   = 3;
    localparam int BLOCK   = 64;
    localparam int PAGE    = 192;
    localparam int DEPTH   = 384;
    localparam int WORD_W  = 64;
    localparam int ENTRY_W = WORD_W + 1;
    localparam int OFF_W   = $clog2(DEPTH);
    localparam int ROT_W   = $clog2(LINKS);
    localparam int BPOS_W  = $clog2(BLOCK);

    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [ROT_W-1:0]   rot_t;
    typedef logic [BPOS_W-1:0]  bpos_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic              new_event;
        logic [WORD_W-1:0] link0_data;
        logic              link0_valid;
        logic [WORD_W-1:0] link1_data;
        logic              link1_valid;
        logic [WORD_W-1:0] link2_data;
        logic              link2_valid;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out0_data;
        logic              out0_valid;
        logic [WORD_W-1:0] out1_data;
        logic              out1_valid;
        logic [WORD_W-1:0] out2_data;
        logic              out2_valid;
        logic              output_active;
    } out_t;

    // Start offset of a link's block for a given page; called with constant arguments only.
    function automatic off_t base_offset(int link, bit fold);
        int v;
        v = link * BLOCK + (fold ? PAGE : 0);
        return off_t'(v % DEPTH);
    endfunction

    // Reads begin on the second page of each memory.
    localparam off_t READ_START = off_t'(PAGE % DEPTH);

endpackage

### sv/time_demultiplexer_link_transpose_unit.sv
// Top level of the time demultiplexer link transpose block.
// A request passes the memory read register, then the output register; while m_ready keeps up
// one request is taken per cycle, and each memory takes one write and one read per cycle.
// Reset (synchronous, active low) clears all counters and starts a clearing pass that zeroes
// every memory entry (DEPTH = 384), one address per cycle, with s_ready held low.
// After the pass the block accepts requests continuously as long as m_ready keeps up.
module time_demultiplexer_link_transpose_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tdlt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tdlt_pkg::out_t m_data
);

    // Write side state: page folds, per-link write offsets, the link-to-memory rotation,
    // and the request count split into a position inside the block and a block index.
    logic [tdlt_pkg::LINKS-1:0] fold_reg, fold_next;
    tdlt_pkg::off_t             off_reg [tdlt_pkg::LINKS];
    tdlt_pkg::off_t             off_next [tdlt_pkg::LINKS];
    tdlt_pkg::rot_t             wrot_reg, wrot_next;
    tdlt_pkg::bpos_t            bpos_reg, bpos_next;
    tdlt_pkg::rot_t             bidx_reg, bidx_next;

    // Read side state.
    logic                       ract_reg, ract_next;
    tdlt_pkg::off_t             raddr_reg, raddr_next;
    tdlt_pkg::bpos_t            rcnt_reg, rcnt_next;
    tdlt_pkg::rot_t             rrot_reg, rrot_next;

    // Clearing pass after reset.
    logic                       clr_reg;
    tdlt_pkg::off_t             clr_addr_reg;

    // State as seen after a new event has restarted the write side.
    logic [tdlt_pkg::LINKS-1:0] e_fold;
    tdlt_pkg::off_t             e_off [tdlt_pkg::LINKS];
    tdlt_pkg::rot_t             e_wrot;
    tdlt_pkg::bpos_t            e_bpos;
    tdlt_pkg::rot_t             e_bidx;
    logic                       e_ract;

    // Memory ports.
    logic [tdlt_pkg::WORD_W-1:0] link_data [tdlt_pkg::LINKS];
    logic [tdlt_pkg::LINKS-1:0]  link_valid;
    tdlt_pkg::rot_t              mem_of [tdlt_pkg::LINKS];
    tdlt_pkg::off_t              wsel_addr [tdlt_pkg::LINKS];
    tdlt_pkg::entry_t            wsel_data [tdlt_pkg::LINKS];
    tdlt_pkg::off_t              mem_wa [tdlt_pkg::LINKS];
    tdlt_pkg::entry_t            mem_wd [tdlt_pkg::LINKS];
    logic                        mem_we;
    logic                        rd_en;
    tdlt_pkg::entry_t            mem_q_reg [tdlt_pkg::LINKS];

    // Read stage: one request in flight between the memory read and the output register.
    logic                        v1_reg;
    logic                        act1_reg;
    tdlt_pkg::rot_t              rrot1_reg;
    logic [tdlt_pkg::LINKS-1:0]  fwd_hit1_reg;
    tdlt_pkg::entry_t            fwd_data1_reg [tdlt_pkg::LINKS];

    logic                        ov_reg;
    tdlt_pkg::out_t              out_reg;
    tdlt_pkg::out_t              out_next;
    tdlt_pkg::entry_t            word [tdlt_pkg::LINKS];
    tdlt_pkg::entry_t            o_word [tdlt_pkg::LINKS];

    logic s_fire;
    logic adv1;
    logic frame_end;
    logic start_read;
    tdlt_pkg::bpos_t bpos1;
    tdlt_pkg::rot_t  bidx1;

    // The read stage may move on whenever the output register is empty or being emptied.
    assign adv1    = !ov_reg || m_ready;
    assign s_ready = !clr_reg && (!v1_reg || adv1);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = ov_reg;
    assign m_data  = out_reg;

    assign link_data[0]  = s_data.link0_data;
    assign link_data[1]  = s_data.link1_data;
    assign link_data[2]  = s_data.link2_data;
    assign link_valid[0] = s_data.link0_valid;
    assign link_valid[1] = s_data.link1_valid;
    assign link_valid[2] = s_data.link2_valid;

    // A new event restarts the write side and stops reading before this request's write.
    always_comb begin
        if (s_data.new_event) begin
            e_wrot = '0;
            e_bpos = '0;
            e_bidx = '0;
            e_ract = 1'b0;
            for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                e_fold[i] = (i == 0);
                e_off[i]  = tdlt_pkg::base_offset(i, (i == 0));
            end
        end else begin
            e_wrot = wrot_reg;
            e_bpos = bpos_reg;
            e_bidx = bidx_reg;
            e_ract = ract_reg;
            e_fold = fold_reg;
            for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                e_off[i] = off_reg[i];
            end
        end
    end

    // Link i goes to memory (rotation + i) mod LINKS.
    always_comb begin
        logic [tdlt_pkg::ROT_W:0] sum;
        for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
            sum = {1'b0, e_wrot} + (tdlt_pkg::ROT_W+1)'(i);
            if (sum >= (tdlt_pkg::ROT_W+1)'(tdlt_pkg::LINKS)) begin
                sum = sum - (tdlt_pkg::ROT_W+1)'(tdlt_pkg::LINKS);
            end
            mem_of[i] = sum[tdlt_pkg::ROT_W-1:0];
        end
        for (int m = 0; m < tdlt_pkg::LINKS; m++) begin
            wsel_addr[m] = e_off[0];
            wsel_data[m] = {link_valid[0], link_data[0]};
            for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                if (mem_of[i] == tdlt_pkg::rot_t'(m)) begin
                    wsel_addr[m] = e_off[i];
                    wsel_data[m] = {link_valid[i], link_data[i]};
                end
            end
        end
    end

    // During the clearing pass every memory gets a zero at the sweep address.
    assign mem_we = clr_reg || s_fire;
    assign rd_en  = s_fire && e_ract;
    always_comb begin
        for (int m = 0; m < tdlt_pkg::LINKS; m++) begin
            mem_wa[m] = clr_reg ? clr_addr_reg : wsel_addr[m];
            mem_wd[m] = clr_reg ? '0 : wsel_data[m];
        end
    end

    // Frame and block bookkeeping. A frame ends every LINKS requests; when the frame
    // also ends a block, the link whose block is done flips its page and restarts.
    always_comb begin
        bpos1 = (e_bpos == tdlt_pkg::bpos_t'(tdlt_pkg::BLOCK - 1)) ? '0
              : e_bpos + tdlt_pkg::bpos_t'(1);
        bidx1 = e_bidx;
        if (e_bpos == tdlt_pkg::bpos_t'(tdlt_pkg::BLOCK - 1)) begin
            bidx1 = (e_bidx == tdlt_pkg::rot_t'(tdlt_pkg::LINKS - 1)) ? '0
                  : e_bidx + tdlt_pkg::rot_t'(1);
        end
        bpos_next = bpos1;
        bidx_next = bidx1;
        frame_end = (e_wrot == tdlt_pkg::rot_t'(tdlt_pkg::LINKS - 1));
        fold_next = e_fold;
        for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
            off_next[i] = e_off[i];
        end
        if (frame_end) begin
            wrot_next = '0;
            for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                if (bpos1 == '0 && bidx1 == tdlt_pkg::rot_t'(i)) begin
                    fold_next[i] = !e_fold[i];
                    off_next[i]  = e_fold[i] ? tdlt_pkg::base_offset(i, 1'b0)
                                             : tdlt_pkg::base_offset(i, 1'b1);
                end else begin
                    off_next[i] = (e_off[i] == tdlt_pkg::off_t'(tdlt_pkg::DEPTH - 1)) ? '0
                                : e_off[i] + tdlt_pkg::off_t'(1);
                end
            end
        end else begin
            wrot_next = e_wrot + tdlt_pkg::rot_t'(1);
        end
    end

    // Reading starts once (LINKS-1)*BLOCK+1 requests have been written; the start request
    // itself still returns zeros.
    always_comb begin
        start_read = (bidx1 == tdlt_pkg::rot_t'(tdlt_pkg::LINKS - 1))
                  && (bpos1 == tdlt_pkg::bpos_t'(1));
        raddr_next = raddr_reg;
        rcnt_next  = rcnt_reg;
        rrot_next  = rrot_reg;
        if (e_ract) begin
            ract_next  = 1'b1;
            raddr_next = (raddr_reg == tdlt_pkg::off_t'(tdlt_pkg::DEPTH - 1)) ? '0
                       : raddr_reg + tdlt_pkg::off_t'(1);
            if (rcnt_reg == tdlt_pkg::bpos_t'(tdlt_pkg::BLOCK - 1)) begin
                rcnt_next = '0;
                rrot_next = (rrot_reg == tdlt_pkg::rot_t'(tdlt_pkg::LINKS - 1)) ? '0
                          : rrot_reg + tdlt_pkg::rot_t'(1);
            end else begin
                rcnt_next = rcnt_reg + tdlt_pkg::bpos_t'(1);
            end
        end else begin
            ract_next = start_read;
            if (start_read) begin
                raddr_next = tdlt_pkg::READ_START;
                rcnt_next  = '0;
                rrot_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrot_reg     <= '0;
            bpos_reg     <= '0;
            bidx_reg     <= '0;
            ract_reg     <= 1'b0;
            raddr_reg    <= '0;
            rcnt_reg     <= '0;
            rrot_reg     <= '0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                fold_reg[i] <= (i == 0);
                off_reg[i]  <= tdlt_pkg::base_offset(i, (i == 0));
            end
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + tdlt_pkg::off_t'(1);
                if (clr_addr_reg == tdlt_pkg::off_t'(tdlt_pkg::DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                wrot_reg  <= wrot_next;
                bpos_reg  <= bpos_next;
                bidx_reg  <= bidx_next;
                fold_reg  <= fold_next;
                ract_reg  <= ract_next;
                raddr_reg <= raddr_next;
                rcnt_reg  <= rcnt_next;
                rrot_reg  <= rrot_next;
                for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
                    off_reg[i] <= off_next[i];
                end
            end
        end
    end

    // One memory per link position. The read returns the old entry when it hits the
    // address written in the same cycle, so that case is forwarded around the memory.
    for (genvar m = 0; m < tdlt_pkg::LINKS; m++) begin : g_mem
        tdlt_pkg::entry_t ram [tdlt_pkg::DEPTH];
        always_ff @(posedge aclk) begin
            if (mem_we) begin
                ram[mem_wa[m]] <= mem_wd[m];
            end
            if (rd_en) begin
                mem_q_reg[m] <= ram[raddr_reg];
            end
        end
    end

    // Read stage control; the memory output holds while no new request is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_fire) begin
            v1_reg <= 1'b1;
        end else if (adv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act1_reg  <= e_ract;
            rrot1_reg <= rrot_reg;
            for (int m = 0; m < tdlt_pkg::LINKS; m++) begin
                fwd_hit1_reg[m]  <= (wsel_addr[m] == raddr_reg);
                fwd_data1_reg[m] <= wsel_data[m];
            end
        end
    end

    // Output link i takes memory (i + read rotation) mod LINKS; inactive results are zero.
    always_comb begin
        logic [tdlt_pkg::ROT_W:0] sum;
        for (int m = 0; m < tdlt_pkg::LINKS; m++) begin
            word[m] = fwd_hit1_reg[m] ? fwd_data1_reg[m] : mem_q_reg[m];
        end
        for (int i = 0; i < tdlt_pkg::LINKS; i++) begin
            sum = {1'b0, rrot1_reg} + (tdlt_pkg::ROT_W+1)'(i);
            if (sum >= (tdlt_pkg::ROT_W+1)'(tdlt_pkg::LINKS)) begin
                sum = sum - (tdlt_pkg::ROT_W+1)'(tdlt_pkg::LINKS);
            end
            o_word[i] = act1_reg ? word[sum[tdlt_pkg::ROT_W-1:0]] : '0;
        end
        out_next.out0_data     = o_word[0][tdlt_pkg::WORD_W-1:0];
        out_next.out0_valid    = o_word[0][tdlt_pkg::WORD_W];
        out_next.out1_data     = o_word[1][tdlt_pkg::WORD_W-1:0];
        out_next.out1_valid    = o_word[1][tdlt_pkg::WORD_W];
        out_next.out2_data     = o_word[2][tdlt_pkg::WORD_W-1:0];
        out_next.out2_valid    = o_word[2][tdlt_pkg::WORD_W];
        out_next.output_active = act1_reg;
    end

    // Output register: loads whenever the read stage holds a result and it may advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (v1_reg && adv1) begin
            ov_reg <= 1'b1;
        end else if (m_ready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && adv1) begin
            out_reg <= out_next;
        end
    end

endmodule

### sv/tdlt_checker.sv
// Port-level checker for the link transpose block and its bind statement.
module tdlt_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input tdlt_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input tdlt_pkg::out_t m_data
);

    // A stalled result must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset always starts the clearing pass, so no request is taken right after it.
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request accepted right after reset");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // Results from before reading starts carry no memory words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.output_active |->
            m_data.out0_data == '0 && !m_data.out0_valid &&
            m_data.out1_data == '0 && !m_data.out1_valid &&
            m_data.out2_data == '0 && !m_data.out2_valid)
        else $error("inactive result carries data");

endmodule

bind time_demultiplexer_link_transpose_unit tdlt_checker u_tdlt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
